@@ src/aabb_frustum_classifier_assert.svh @@
// Assertion macros used by the frustum classifier checker.
`ifndef AABB_FRUSTUM_CLASSIFIER_ASSERT_SVH
`define AABB_FRUSTUM_CLASSIFIER_ASSERT_SVH

`define AFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define AFC_ASSERT_LATENCY(label, cond, n, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> ##n done_o) \
    else $error(msg);

`endif

@@ src/afc_pkg.sv @@
// Types and constants of the box versus frustum classifier.
package afc_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned ExtW     = 31;
  localparam int unsigned MagW     = 33;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned WideW    = 72;
  localparam int unsigned RouteW   = 2;
  localparam int unsigned Latency  = 5;

  localparam int unsigned EpsZLsb    = 1;
  localparam int unsigned EpsWLsb    = 7;
  localparam int unsigned EpsSideLsb = 1;

  typedef enum logic [RouteW-1:0] {
    ROUTE_FAST   = 2'd0,
    ROUTE_REJECT = 2'd1,
    ROUTE_CLIP   = 2'd2
  } route_e;

endpackage

@@ src/aabb_frustum_classifier.sv @@
// Top level of the box versus frustum classifier with a five stage pipeline.
// A box request is taken at every rising edge with start_i high; busy_o stays
// low, so one box can enter in every cycle. The 4x4 clip matrix is written through
// cfg_we_i, cfg_idx_i and cfg_data_i, two signed Q entries per register, and is
// sampled when a box enters. Stage one registers the box, the matrix entries
// and the plane coefficient magnitudes; stage two forms all products; stage
// three sums clip coordinates and plane radii; stage four forms plane centers;
// stage five bounds every plane, compares against the epsilons and registers
// the route. A request accepted at one edge shows its route on route_o with
// done_o high once its route is registered in stage five. No stage can
// stall, so throughput is one box per cycle.
// Reset clears the matrix and the stage valid bits; no result is lost in
// flight other than those cancelled by reset. The receiver cannot stall, and
// each route is shown for exactly one cycle.
module aabb_frustum_classifier #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  cfg_we_i,
  input  logic [afc_pkg::CfgIdxW-1:0]           cfg_idx_i,
  input  logic [afc_pkg::CfgDataW-1:0]          cfg_data_i,
  input  logic signed [afc_pkg::CoordW-1:0]     center_x_i,
  input  logic signed [afc_pkg::CoordW-1:0]     center_y_i,
  input  logic signed [afc_pkg::CoordW-1:0]     center_z_i,
  input  logic [afc_pkg::ExtW-1:0]              extent_x_i,
  input  logic [afc_pkg::ExtW-1:0]              extent_y_i,
  input  logic [afc_pkg::ExtW-1:0]              extent_z_i,
  output logic                                  done_o,
  output logic [afc_pkg::RouteW-1:0]            route_o
);
  import afc_pkg::*;

  localparam logic signed [WideW-1:0] EpsZ    = WideW'(EpsZLsb) <<< (2 * FRAC_BITS);
  localparam logic signed [WideW-1:0] EpsW    = WideW'(EpsWLsb) <<< (2 * FRAC_BITS);
  localparam logic signed [WideW-1:0] EpsSide = WideW'(EpsSideLsb) <<< (2 * FRAC_BITS);

  function automatic logic [MagW-1:0] abs_sum(input logic signed [CoordW-1:0] a,
                                              input logic signed [CoordW-1:0] b,
                                              input logic sub);
    logic signed [MagW-1:0] s;
    s = sub ? (MagW'(a) - MagW'(b)) : (MagW'(a) + MagW'(b));
    return s[MagW-1] ? MagW'(-s) : s;
  endfunction

  logic [CfgDataW-1:0] mat_q [NumCfg];
  logic signed [CoordW-1:0] m_ent [4][4];
  logic [MagW-1:0] mag_d [6][3];

  logic [Latency-1:0] vld_q;

  logic signed [CoordW-1:0] s1_ctr_q [3];
  logic [ExtW-1:0]          s1_ext_q [3];
  logic signed [CoordW-1:0] s1_m_q   [3][4];
  logic signed [CoordW-1:0] s1_t_q   [4];
  logic [MagW-1:0]          s1_mag_q [6][3];

  logic signed [ProdW-1:0]  s2_prod_q [3][4];
  logic signed [CoordW-1:0] s2_t_q    [4];
  logic [ProdW-1:0]         s2_rp_q   [6][3];

  logic signed [WideW-1:0] s3_clip_d [4];
  logic signed [WideW-1:0] s3_clip_q [4];
  logic signed [WideW-1:0] s3_rad_d  [6];
  logic signed [WideW-1:0] s3_rad_q  [6];

  logic signed [WideW-1:0] s4_cen_d [6];
  logic signed [WideW-1:0] s4_cen_q [6];
  logic signed [WideW-1:0] s4_rad_q [6];

  logic signed [WideW-1:0] mn [6];
  logic signed [WideW-1:0] mx [6];
  logic   fast, reject;
  route_e route_d, route_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumCfg; k++) begin
        mat_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m_ent[r][c] = mat_q[CfgIdxW'(2 * r + c / 2)][(c % 2) * CoordW +: CoordW];
      end
    end
    for (int i = 0; i < 3; i++) begin
      mag_d[0][i] = abs_sum(m_ent[i][2], '0, 1'b0);
      mag_d[1][i] = abs_sum(m_ent[i][3], '0, 1'b0);
      mag_d[2][i] = abs_sum(m_ent[i][3], m_ent[i][0], 1'b0);
      mag_d[3][i] = abs_sum(m_ent[i][3], m_ent[i][0], 1'b1);
      mag_d[4][i] = abs_sum(m_ent[i][3], m_ent[i][1], 1'b0);
      mag_d[5][i] = abs_sum(m_ent[i][3], m_ent[i][1], 1'b1);
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      s3_clip_d[j] = (WideW'(s2_t_q[j]) <<< FRAC_BITS) + WideW'(s2_prod_q[0][j])
                   + WideW'(s2_prod_q[1][j]) + WideW'(s2_prod_q[2][j]);
    end
    for (int k = 0; k < 6; k++) begin
      s3_rad_d[k] = $signed(WideW'(s2_rp_q[k][0]) + WideW'(s2_rp_q[k][1])
                          + WideW'(s2_rp_q[k][2]));
    end
  end

  always_comb begin
    s4_cen_d[0] = s3_clip_q[2];
    s4_cen_d[1] = s3_clip_q[3];
    s4_cen_d[2] = s3_clip_q[3] + s3_clip_q[0];
    s4_cen_d[3] = s3_clip_q[3] - s3_clip_q[0];
    s4_cen_d[4] = s3_clip_q[3] + s3_clip_q[1];
    s4_cen_d[5] = s3_clip_q[3] - s3_clip_q[1];
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      mn[k] = s4_cen_q[k] - s4_rad_q[k];
      mx[k] = s4_cen_q[k] + s4_rad_q[k];
    end
    fast   = (mn[0] >= EpsZ) && (mn[1] >= EpsW);
    reject = (mx[0] < -EpsZ) || (mx[1] < EpsW);
    for (int k = 2; k < 6; k++) begin
      fast   = fast && (mn[k] >= EpsSide);
      reject = reject || (mx[k] < -EpsSide);
    end
    if (fast) begin
      route_d = ROUTE_FAST;
    end else if (reject) begin
      route_d = ROUTE_REJECT;
    end else begin
      route_d = ROUTE_CLIP;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctr_q[0] <= center_x_i;
    s1_ctr_q[1] <= center_y_i;
    s1_ctr_q[2] <= center_z_i;
    s1_ext_q[0] <= extent_x_i;
    s1_ext_q[1] <= extent_y_i;
    s1_ext_q[2] <= extent_z_i;
    for (int j = 0; j < 4; j++) begin
      s1_t_q[j] <= m_ent[3][j];
      s2_t_q[j] <= s1_t_q[j];
      s3_clip_q[j] <= s3_clip_d[j];
      for (int i = 0; i < 3; i++) begin
        s1_m_q[i][j]    <= m_ent[i][j];
        s2_prod_q[i][j] <= s1_ctr_q[i] * s1_m_q[i][j];
      end
    end
    for (int k = 0; k < 6; k++) begin
      for (int i = 0; i < 3; i++) begin
        s1_mag_q[k][i] <= mag_d[k][i];
        s2_rp_q[k][i]  <= ProdW'(s1_mag_q[k][i]) * ProdW'(s1_ext_q[i]);
      end
      s3_rad_q[k] <= s3_rad_d[k];
      s4_cen_q[k] <= s4_cen_d[k];
      s4_rad_q[k] <= s3_rad_q[k];
    end
    route_q <= route_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Latency-2:0], start_i};
    end
  end

  assign busy_o  = 1'b0;
  assign done_o  = vld_q[Latency-1];
  assign route_o = route_q;

endmodule

@@ src/afc_checker.sv @@
// Port level checker of the box versus frustum classifier and its bind.
`include "aabb_frustum_classifier_assert.svh"

module afc_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic                                 cfg_we_i,
  input logic signed [afc_pkg::CoordW-1:0]    center_x_i,
  input logic signed [afc_pkg::CoordW-1:0]    center_y_i,
  input logic signed [afc_pkg::CoordW-1:0]    center_z_i,
  input logic [afc_pkg::ExtW-1:0]             extent_x_i,
  input logic [afc_pkg::ExtW-1:0]             extent_y_i,
  input logic [afc_pkg::ExtW-1:0]             extent_z_i,
  input logic                                 done_o,
  input logic [afc_pkg::RouteW-1:0]           route_o
);
  import afc_pkg::*;

  localparam int unsigned BoxW = 3 * CoordW + 3 * ExtW;

  logic same_box;
  logic [BoxW-1:0] box_now;
  logic [BoxW-1:0] box_q;
  logic prev_acc_q;
  logic prev_we_q;

  assign box_now = {center_x_i, center_y_i, center_z_i, extent_x_i, extent_y_i, extent_z_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_acc_q <= 1'b0;
      prev_we_q  <= 1'b0;
      box_q      <= '0;
    end else begin
      prev_acc_q <= start_i && !busy_o;
      prev_we_q  <= cfg_we_i;
      box_q      <= box_now;
    end
  end

  // Two identical boxes in a row with the matrix untouched must route the same.
  assign same_box = start_i && !busy_o && prev_acc_q && !prev_we_q && (box_now == box_q);

  `AFC_ASSERT_LATENCY(a_req_done, start_i && !busy_o, 5, "request without a result")
  `AFC_ASSERT(a_done_req, done_o |-> $past(start_i && !busy_o, Latency), "result without request")
  `AFC_ASSERT(a_same_box, same_box |-> ##5 (route_o == $past(route_o)), "repeated box changed route")

endmodule

bind aabb_frustum_classifier afc_checker u_afc_checker (.*);

@@ dv/tb_top.sv @@
// Self-checking testbench for the box versus frustum classifier, with predictor, driver and monitor.
`timescale 1ns / 1ps

module tb_top;
  import afc_pkg::*;

  localparam int FracBits = 16;
  localparam int One = 1 << FracBits;
  localparam int RandPerPhase = 143;
  localparam int CycleLimit = 200000;

  localparam logic [CfgIdxW-1:0] RegR1C12 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegR1C34 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegR2C12 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegR2C34 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegR3C12 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegR3C34 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegR4C12 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegR4C34 = 3'd7;

  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [ExtW-1:0] ExtMax = '1;

  localparam logic signed [127:0] EpsZ = 128'(EpsZLsb) <<< (2 * FracBits);
  localparam logic signed [127:0] EpsW = 128'(EpsWLsb) <<< (2 * FracBits);
  localparam logic signed [127:0] EpsSide = 128'(EpsSideLsb) <<< (2 * FracBits);

  typedef enum int {MatOrtho, MatPersp, MatFull, MatMaxPos, MatMinNeg, MatMixed} mat_kind_e;

  typedef struct {
    logic signed [CoordW-1:0] cx, cy, cz;
    logic [ExtW-1:0] ex, ey, ez;
  } box_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic signed [CoordW-1:0] center_x_i = '0;
  logic signed [CoordW-1:0] center_y_i = '0;
  logic signed [CoordW-1:0] center_z_i = '0;
  logic [ExtW-1:0] extent_x_i = '0;
  logic [ExtW-1:0] extent_y_i = '0;
  logic [ExtW-1:0] extent_z_i = '0;
  logic done_o;
  logic [RouteW-1:0] route_o;

  logic signed [CoordW-1:0] clip_mat [4][4];
  box_t pending_boxes [$];
  route_e expected_routes [$];
  logic gaps_on = 1'b1;
  int boxes_sent = 0;
  int routes_checked = 0;
  int route_seen [4] = '{0, 0, 0, 0};
  int mismatches = 0;
  int cycle_count = 0;
  int mat_settings = 1;

  aabb_frustum_classifier #(
    .FRAC_BITS(FracBits)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .center_z_i(center_z_i),
    .extent_x_i(extent_x_i),
    .extent_y_i(extent_y_i),
    .extent_z_i(extent_z_i),
    .done_o    (done_o),
    .route_o   (route_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic route_e classify_box(box_t b);
    logic signed [127:0] m [4][4];
    logic signed [127:0] ctr [3];
    logic signed [127:0] ext [3];
    logic signed [127:0] clip [4];
    logic signed [127:0] cen [6];
    logic signed [127:0] coef, rad, lo, hi;
    logic fast, rej;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = clip_mat[r][c];
      end
    end
    ctr[0] = b.cx;
    ctr[1] = b.cy;
    ctr[2] = b.cz;
    ext[0] = {97'd0, b.ex};
    ext[1] = {97'd0, b.ey};
    ext[2] = {97'd0, b.ez};
    for (int j = 0; j < 4; j++) begin
      clip[j] = m[3][j] <<< FracBits;
      for (int i = 0; i < 3; i++) begin
        clip[j] = clip[j] + ctr[i] * m[i][j];
      end
    end
    cen[0] = clip[2];
    cen[1] = clip[3];
    cen[2] = clip[3] + clip[0];
    cen[3] = clip[3] - clip[0];
    cen[4] = clip[3] + clip[1];
    cen[5] = clip[3] - clip[1];
    fast = 1'b1;
    rej = 1'b0;
    for (int p = 0; p < 6; p++) begin
      rad = '0;
      for (int i = 0; i < 3; i++) begin
        case (p)
          0: coef = m[i][2];
          1: coef = m[i][3];
          2: coef = m[i][3] + m[i][0];
          3: coef = m[i][3] - m[i][0];
          4: coef = m[i][3] + m[i][1];
          default: coef = m[i][3] - m[i][1];
        endcase
        if (coef < 0) coef = -coef;
        rad = rad + coef * ext[i];
      end
      lo = cen[p] - rad;
      hi = cen[p] + rad;
      case (p)
        0: begin
          fast = fast && (lo >= EpsZ);
          rej = rej || (hi < -EpsZ);
        end
        1: begin
          fast = fast && (lo >= EpsW);
          rej = rej || (hi < EpsW);
        end
        default: begin
          fast = fast && (lo >= EpsSide);
          rej = rej || (hi < -EpsSide);
        end
      endcase
    end
    if (fast) return ROUTE_FAST;
    if (rej) return ROUTE_REJECT;
    return ROUTE_CLIP;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Requests go out from the pending queue; each accepted request yields its predicted route.
  always @(posedge clk_i) begin
    box_t cur;
    box_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        cur.cx = center_x_i;
        cur.cy = center_y_i;
        cur.cz = center_z_i;
        cur.ex = extent_x_i;
        cur.ey = extent_y_i;
        cur.ez = extent_z_i;
        expected_routes.push_back(classify_box(cur));
        boxes_sent++;
      end
      if (!start_i || !busy_o) begin
        if (pending_boxes.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 20)) begin
          nxt = pending_boxes.pop_front();
          start_i <= 1'b1;
          center_x_i <= nxt.cx;
          center_y_i <= nxt.cy;
          center_z_i <= nxt.cz;
          extent_x_i <= nxt.ex;
          extent_y_i <= nxt.ey;
          extent_z_i <= nxt.ez;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // The route is registered, so it is stable at the falling edge of its strobe cycle.
  always @(negedge clk_i) begin
    route_e want;
    if (rst_ni && done_o) begin
      route_seen[route_o]++;
      if (expected_routes.size() == 0) begin
        report_mismatch($sformatf("route %0d returned with no box outstanding", route_o));
      end else begin
        want = expected_routes.pop_front();
        if (route_o !== want) begin
          report_mismatch($sformatf("box %0d: route %0d, predicted %0d",
                                    routes_checked, route_o, want));
        end
        routes_checked++;
      end
    end
  end

  task automatic add_box(input logic signed [CoordW-1:0] cx, cy, cz,
                         input int unsigned ex, ey, ez);
    box_t b;
    b.cx = cx;
    b.cy = cy;
    b.cz = cz;
    b.ex = ExtW'(ex);
    b.ey = ExtW'(ey);
    b.ez = ExtW'(ez);
    pending_boxes.push_back(b);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(0, 32 * One) - 16 * One;
    if (pick < 95) return $urandom;
    case ($urandom_range(0, 2))
      0: return CoordMin;
      1: return CoordMax;
      default: return '0;
    endcase
  endfunction

  function automatic logic [ExtW-1:0] rand_extent();
    int unsigned pick;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    raw = $urandom;
    if (pick < 70) return ExtW'($urandom_range(0, 4 * One));
    if (pick < 85) return raw[ExtW-1:0];
    if (pick < 95) return '0;
    return ExtMax;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_boxes.size() != 0 || start_i || expected_routes.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
  endtask

  task automatic load_matrix();
    write_reg(RegR1C12, {clip_mat[0][1], clip_mat[0][0]});
    write_reg(RegR1C34, {clip_mat[0][3], clip_mat[0][2]});
    write_reg(RegR2C12, {clip_mat[1][1], clip_mat[1][0]});
    write_reg(RegR2C34, {clip_mat[1][3], clip_mat[1][2]});
    write_reg(RegR3C12, {clip_mat[2][1], clip_mat[2][0]});
    write_reg(RegR3C34, {clip_mat[2][3], clip_mat[2][2]});
    write_reg(RegR4C12, {clip_mat[3][1], clip_mat[3][0]});
    write_reg(RegR4C34, {clip_mat[3][3], clip_mat[3][2]});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    mat_settings++;
  endtask

  task automatic pick_matrix(input mat_kind_e kind);
    logic [31:0] extremes [5];
    extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1};
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        case (kind)
          MatFull: clip_mat[r][c] = $urandom;
          MatMaxPos: clip_mat[r][c] = 32'h7FFF_FFFF;
          MatMinNeg: clip_mat[r][c] = 32'h8000_0000;
          MatMixed: clip_mat[r][c] = extremes[$urandom_range(0, 4)];
          default: clip_mat[r][c] = $urandom_range(0, One / 8) - One / 16;
        endcase
      end
    end
    if (kind == MatOrtho) begin
      for (int i = 0; i < 3; i++) begin
        clip_mat[i][i] = $urandom_range(One / 4, 2 * One);
        clip_mat[3][i] = $urandom_range(0, 4 * One) - 2 * One;
      end
      clip_mat[3][3] = $urandom_range(8 * One, 16 * One);
    end else if (kind == MatPersp) begin
      clip_mat[0][0] = $urandom_range(One / 2, 2 * One);
      clip_mat[1][1] = $urandom_range(One / 2, 2 * One);
      clip_mat[2][2] = $urandom_range(One, 2 * One);
      clip_mat[3][2] = -$urandom_range(One / 2, 2 * One);
      clip_mat[2][3] = One;
      clip_mat[3][3] = $urandom_range(0, 8 * One);
    end
  endtask

  initial begin
    mat_kind_e plan [10];
    plan = '{MatPersp, MatFull, MatOrtho, MatMaxPos, MatPersp,
             MatMixed, MatMinNeg, MatOrtho, MatPersp, MatFull};
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        clip_mat[r][c] = '0;
      end
    end
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the all-zero matrix from reset, the w plane rejects every box.
    @(negedge clk_i);
    add_box(0, 0, 0, 0, 0, 0);
    add_box(CoordMax, CoordMax, CoordMax, ExtMax, ExtMax, ExtMax);
    add_box(CoordMin, CoordMin, CoordMin, 0, 0, 0);
    add_box(rand_coord(), rand_coord(), rand_coord(), rand_extent(), rand_extent(),
            rand_extent());

    // Orthographic view, w fixed at 8.0; boxes straddle both z bounds and one x and one y bound.
    wait_idle();
    for (int i = 0; i < 3; i++) clip_mat[i][i] = One;
    clip_mat[3][3] = 8 * One;
    load_matrix();
    add_box(0, 0, 2 * One, One, One, One);
    add_box(20 * One, 0, 2 * One, One, One, One);
    add_box(8 * One, 0, 2 * One, One, One, One);
    add_box(0, 0, -5 * One, One, One, One);
    add_box(0, 0, One, 0, 0, 0);
    add_box(0, 0, One - 1, 0, 0, 0);
    add_box(0, 0, -One, 0, 0, 0);
    add_box(0, 0, -One - 1, 0, 0, 0);
    add_box(7 * One, 0, 2 * One, 0, 0, 0);
    add_box(7 * One + 1, 0, 2 * One, 0, 0, 0);
    add_box(0, -9 * One, 2 * One, 0, 0, 0);
    add_box(0, -9 * One - 1, 2 * One, 0, 0, 0);
    add_box(CoordMax, CoordMax, CoordMax, ExtMax, ExtMax, ExtMax);
    add_box(CoordMin, CoordMin, CoordMin, ExtMax, ExtMax, ExtMax);
    add_box(0, 0, 0, ExtMax, ExtMax, ExtMax);
    add_box(CoordMax, CoordMin, CoordMax, 0, 0, 0);
    add_box(CoordMin, CoordMax, CoordMin, 0, ExtMax, 0);

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      pick_matrix(plan[p]);
      load_matrix();
      gaps_on = (p != 4);
      repeat (RandPerPhase) begin
        add_box(rand_coord(), rand_coord(), rand_coord(), rand_extent(), rand_extent(),
                rand_extent());
      end
    end

    wait_idle();
    repeat (4 * Latency) @(negedge clk_i);
    $display("Classified %0d boxes under %0d matrix settings, zero and extreme ones included.",
             boxes_sent, mat_settings);
    $display("Routes seen: %0d fast, %0d rejected, %0d clipped; %0d mismatches.",
             route_seen[ROUTE_FAST], route_seen[ROUTE_REJECT], route_seen[ROUTE_CLIP],
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
